// ===== src/frw_pkg.sv =====
// Package with the shared constants, codes, types and pointer helpers of the framed ring writer.
`timescale 1ns / 1ps

package frw_pkg;

  localparam int unsigned RING_BYTES = 16384;
  localparam int unsigned PTR_W      = $clog2(RING_BYTES);
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned TOT_W      = LEN_W + 1;
  localparam int unsigned FREE_W     = 14;
  localparam int unsigned HDR_BYTES  = 3;

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_BYTES - 1);
  localparam logic [TOT_W-1:0] TOT_MAX   = TOT_W'(RING_BYTES - 1);
  localparam logic [LEN_W-1:0] LEN_TRUNC = LEN_W'(RING_BYTES - 1 - HDR_BYTES);

  // Kind of an input item, carried in tuser.
  localparam logic [1:0] MODE_HDR  = 2'd0;
  localparam logic [1:0] MODE_PAY  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Result status codes.
  localparam logic [2:0] STS_ACCEPTED  = 3'd0;
  localparam logic [2:0] STS_PUBLISHED = 3'd1;
  localparam logic [2:0] STS_NOROOM    = 3'd2;
  localparam logic [2:0] STS_DISCARDED = 3'd3;
  localparam logic [2:0] STS_READOK    = 3'd4;
  localparam logic [2:0] STS_EMPTY     = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR_LO,
    ST_HDR_HI,
    ST_RD
  } frw_state_e;

  // One write request to the ring memory.
  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [7:0]       data;
  } frw_wr_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_LAST) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Free bytes with one slot kept unused: RING_BYTES-1 minus the bytes from rp to wp.
  function automatic logic [FREE_W-1:0] free_calc(input logic [PTR_W-1:0] wp,
                                                  input logic [PTR_W-1:0] rp);
    logic [PTR_W:0] used;
    logic [PTR_W:0] free;
    if (wp >= rp) begin
      used = {1'b0, wp} - {1'b0, rp};
    end else begin
      used = {1'b0, wp} + (PTR_W+1)'(RING_BYTES) - {1'b0, rp};
    end
    free = (PTR_W+1)'(RING_BYTES - 1) - used;
    return FREE_W'(free);
  endfunction

endpackage

// ===== src/frw_ring_ram.sv =====
// Byte ring memory with one write port and one registered read port.
`timescale 1ns / 1ps

module frw_ring_ram
  import frw_pkg::*;
(
  input  logic             clk_i,
  input  frw_wr_t          wr_i,
  input  logic             rd_en_i,
  input  logic [PTR_W-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem [RING_BYTES];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/framed_ring_writer_top.sv =====
// Top level of the framed ring writer: control, pointers, result register and ring memory.
`timescale 1ns / 1ps

// The framed ring writer keeps a byte ring in one synchronous memory. Items arrive on the
// slave stream: tuser gives the kind (frame header, payload byte, consumer read) and tdata
// carries command, length and the payload byte. Every item gives exactly one result item on
// the master stream with a status, the byte read and the free space after the item.
// A header is admitted only when the whole frame fits; its three bytes (command, length low,
// length high) are written one per cycle, and the block takes no new item until they are done.
// A read that finds published data passes through a read state, because the memory read
// port registers its data. The result is registered in the output register when the item is
// accepted (after the memory read for a successful read) and waits there while the receiver
// stalls; when idle, the block accepts the next item in the same cycle the waiting result
// is taken. A frame becomes visible to reads only once its last payload byte has been
// written. The user must write the enable register through cfg_we_i and cfg_wdata_i
// only while the block is idle; the block itself does not enforce this.
// Reset clears the pointers, the open-frame state, the enable bit and the output valid;
// the memory contents are not cleared, as only written bytes are ever read.

module framed_ring_writer_top
  import frw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // enable
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // command[7:0], length[23:8], data_byte[31:24]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // status[2:0], read_byte[10:3], free_space[24:11]
);

  frw_state_e       state_q, state_d;
  logic             enable_q;
  logic [PTR_W-1:0] pub_q, pub_d;
  logic [PTR_W-1:0] pend_q, pend_d;
  logic [PTR_W-1:0] cons_q, cons_d;
  logic             open_q, open_d;
  logic [LEN_W-1:0] left_q, left_d;
  logic [LEN_W-1:0] hdr_len_q, hdr_len_d;
  logic [PTR_W-1:0] wr_addr_q, wr_addr_d;
  logic             m_valid_q, m_valid_d;
  logic [2:0]       m_status_q, m_status_d;
  logic [FREE_W-1:0] m_free_q, m_free_d;

  frw_wr_t          wr;
  logic             rd_en;
  logic [7:0]       rd_data;

  logic             accept;
  logic [1:0]       mode;
  logic [7:0]       cmd;
  logic [LEN_W-1:0] len;
  logic [7:0]       data_byte;

  logic [TOT_W-1:0] total_raw;
  logic             oversize;
  logic [LEN_W-1:0] len_t;
  logic [TOT_W-1:0] total;
  logic             hdr_fits;
  logic             read_avail;
  logic [PTR_W-1:0] pub_plus3;
  logic [PTR_W-1:0] pend_inc;
  logic [PTR_W-1:0] cons_inc;

  assign mode      = s_axis_tuser;
  assign cmd       = s_axis_tdata[7:0];
  assign len       = s_axis_tdata[23:8];
  assign data_byte = s_axis_tdata[31:24];

  // A new item is taken only when no item is in flight and the output register is free
  // or being emptied in this cycle.
  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Frame size check: a frame that could never fit is cut to the largest one that can.
  assign total_raw  = TOT_W'(len) + TOT_W'(HDR_BYTES);
  assign oversize   = total_raw > TOT_MAX;
  assign len_t      = oversize ? LEN_TRUNC : len;
  assign total      = oversize ? TOT_MAX : total_raw;
  assign hdr_fits   = TOT_W'(free_calc(pub_q, cons_q)) >= total;
  assign read_avail = cons_q != pub_q;

  assign pub_plus3 = ptr_inc(ptr_inc(ptr_inc(pub_q)));
  assign pend_inc  = ptr_inc(pend_q);
  assign cons_inc  = ptr_inc(cons_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_HDR && enable_q && hdr_fits) begin
            state_d = ST_HDR_LO;
          end else if (mode == MODE_READ && read_avail) begin
            state_d = ST_RD;
          end
        end
      end
      ST_HDR_LO: state_d = ST_HDR_HI;
      ST_HDR_HI: state_d = ST_IDLE;
      ST_RD:     state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory requests and result register.
  always_comb begin
    pub_d      = pub_q;
    pend_d     = pend_q;
    cons_d     = cons_q;
    open_d     = open_q;
    left_d     = left_q;
    hdr_len_d  = hdr_len_q;
    wr_addr_d  = wr_addr_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_status_d = m_status_q;
    m_free_d   = m_free_q;
    wr         = '0;
    rd_en      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          m_valid_d  = 1'b1;
          m_status_d = STS_DISCARDED;
          m_free_d   = free_calc(pend_q, cons_q);
          case (mode)
            MODE_READ: begin
              if (read_avail) begin
                // Result is shown once the memory has returned the byte.
                m_valid_d  = 1'b0;
                rd_en      = 1'b1;
                cons_d     = cons_inc;
                m_status_d = STS_READOK;
                m_free_d   = free_calc(pend_q, cons_inc);
              end else begin
                m_status_d = STS_EMPTY;
              end
            end
            MODE_HDR: begin
              if (enable_q) begin
                // Any unpublished bytes of an open frame are abandoned here.
                pend_d = pub_q;
                open_d = 1'b0;
                left_d = '0;
                if (hdr_fits) begin
                  wr.en     = 1'b1;
                  wr.addr   = pub_q;
                  wr.data   = cmd;
                  wr_addr_d = ptr_inc(pub_q);
                  hdr_len_d = len_t;
                  pend_d    = pub_plus3;
                  m_free_d  = free_calc(pub_plus3, cons_q);
                  if (len_t == '0) begin
                    pub_d      = pub_plus3;
                    m_status_d = STS_PUBLISHED;
                  end else begin
                    open_d     = 1'b1;
                    left_d     = len_t;
                    m_status_d = STS_ACCEPTED;
                  end
                end else begin
                  m_status_d = STS_NOROOM;
                  m_free_d   = free_calc(pub_q, cons_q);
                end
              end
            end
            MODE_PAY: begin
              if (enable_q && open_q && left_q != '0) begin
                wr.en    = 1'b1;
                wr.addr  = pend_q;
                wr.data  = data_byte;
                pend_d   = pend_inc;
                left_d   = left_q - LEN_W'(1);
                m_free_d = free_calc(pend_inc, cons_q);
                if (left_q == LEN_W'(1)) begin
                  open_d     = 1'b0;
                  pub_d      = pend_inc;
                  m_status_d = STS_PUBLISHED;
                end else begin
                  m_status_d = STS_ACCEPTED;
                end
              end
            end
            default: begin
              m_status_d = STS_DISCARDED;
            end
          endcase
        end
      end
      ST_HDR_LO: begin
        wr.en     = 1'b1;
        wr.addr   = wr_addr_q;
        wr.data   = hdr_len_q[7:0];
        wr_addr_d = ptr_inc(wr_addr_q);
      end
      ST_HDR_HI: begin
        wr.en   = 1'b1;
        wr.addr = wr_addr_q;
        wr.data = hdr_len_q[15:8];
      end
      ST_RD: begin
        m_valid_d = 1'b1;
      end
      default: begin
        m_valid_d = m_valid_q && !m_axis_tready;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      enable_q  <= 1'b0;
      pub_q     <= '0;
      pend_q    <= '0;
      cons_q    <= '0;
      open_q    <= 1'b0;
      left_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pub_q     <= pub_d;
      pend_q    <= pend_d;
      cons_q    <= cons_d;
      open_q    <= open_d;
      left_q    <= left_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_len_q  <= hdr_len_d;
    wr_addr_q  <= wr_addr_d;
    m_status_q <= m_status_d;
    m_free_q   <= m_free_d;
  end

  frw_ring_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (cons_q),
    .rd_data_o (rd_data)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_free_q,
                          (m_status_q == STS_READOK) ? rd_data : 8'd0,
                          m_status_q};

  // No item is taken while a header write or a memory read is still in progress.
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // Without an open frame, no unpublished bytes exist.
  a_closed_frame_pointers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (pend_q == pub_q))
    else $error("pending pointer differs from published pointer with no open frame");

  // An open frame always still expects payload.
  a_open_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (left_q != '0))
    else $error("open frame with no payload bytes left");

  // A memory read always ends in a shown result.
  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (m_axis_tvalid && m_status_q == STS_READOK))
    else $error("read did not deliver its result");

  // Header length bytes follow the command byte in consecutive cycles.
  a_header_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HDR_LO) |=> (state_q == ST_HDR_HI))
    else $error("header write sequence broken");

endmodule

// ===== test/framed_ring_writer_top_test.sv =====
// Self-checking testbench for the framed ring writer: directed and random streams against a predictor.
`timescale 1ns / 1ps

// The testbench drives items on the slave stream and checks each result item against a
// predictor of the ring kept in this file. A clocked driver takes items from a queue that
// the stimulus process fills phase by phase, and a clocked monitor compares every result
// item with the oldest prediction. The enable register is only written between phases,
// once the driver is empty and every predicted result has come back. That drain is also
// the point where the sender pauses until the block has nothing left in flight.

module framed_ring_writer_top_test;
  import frw_pkg::*;

  localparam logic [1:0] MODE_SPARE    = 2'd3;  // unused kind, must be discarded
  localparam int         SETTLE_CYCLES = 6;     // longest item is a header
  localparam longint     CYCLE_LIMIT   = 64'd12_000_000;
  localparam int         PRINT_CAP     = 100;

  // One input item. The three data fields are packed exactly as on tdata.
  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] length;
    logic [7:0]       command;
  } ring_op_t;

  // One result item.
  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        read_byte;
    logic [FREE_W-1:0] free_space;
  } ring_reply_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;     // command[7:0], length[23:8], data_byte[31:24]
  logic [1:0]  s_axis_tuser  = '0;     // mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // status[2:0], read_byte[10:3], free_space[24:11]

  framed_ring_writer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the ring and its pointers, updated as items are accepted.
  logic [7:0]       shadow_ring [RING_BYTES];
  logic [PTR_W-1:0] wr_pub      = '0;   // end of the last published frame
  logic [PTR_W-1:0] wr_pend     = '0;   // next byte the open frame writes
  logic [PTR_W-1:0] rd_ptr      = '0;   // next byte the consumer reads
  logic             frame_live  = 1'b0;
  logic [LEN_W-1:0] bytes_due   = '0;
  logic             ring_enable = 1'b0;

  ring_op_t    pending_ops[$];
  ring_reply_t predicted_replies[$];
  ring_op_t    op_on_bus;

  longint      cycle_count    = 0;
  int unsigned mismatch_count = 0;
  bit          src_idle       = 1'b1;
  bit          sink_idle      = 1'b1;
  int unsigned src_gap        = 0;
  int unsigned sink_wait      = 0;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Free bytes seen from a write position; one slot always stays unused.
  function automatic logic [FREE_W-1:0] room_from(input logic [PTR_W-1:0] wp);
    int unsigned span;
    span = (int'(wp) + RING_BYTES - int'(rd_ptr)) % RING_BYTES;
    return FREE_W'(RING_BYTES - 1 - span);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    shadow_ring[wr_pend] = b;
    wr_pend              = ring_next(wr_pend);
  endfunction

  // Works out the result of one accepted item and advances the shadow state.
  function automatic ring_reply_t ring_predict(input ring_op_t op);
    ring_reply_t      rep;
    logic [LEN_W-1:0] len;
    logic [TOT_W-1:0] need;
    rep.status    = STS_DISCARDED;
    rep.read_byte = 8'h00;
    case (op.mode)
      MODE_READ: begin
        if (rd_ptr == wr_pub) begin
          rep.status = STS_EMPTY;
        end else begin
          rep.read_byte = shadow_ring[rd_ptr];
          rd_ptr        = ring_next(rd_ptr);
          rep.status    = STS_READOK;
        end
      end
      MODE_HDR: begin
        if (ring_enable) begin
          // A new header throws away whatever the open frame had written.
          wr_pend    = wr_pub;
          frame_live = 1'b0;
          bytes_due  = '0;
          len        = op.length;
          need       = TOT_W'(HDR_BYTES) + TOT_W'(len);
          if (need > TOT_MAX) begin
            len  = LEN_TRUNC;
            need = TOT_MAX;
          end
          if (TOT_W'(room_from(wr_pub)) < need) begin
            rep.status = STS_NOROOM;
          end else begin
            put_byte(op.command);
            put_byte(len[7:0]);
            put_byte(len[15:8]);
            if (len == '0) begin
              wr_pub     = wr_pend;
              rep.status = STS_PUBLISHED;
            end else begin
              frame_live = 1'b1;
              bytes_due  = len;
              rep.status = STS_ACCEPTED;
            end
          end
        end
      end
      MODE_PAY: begin
        if (ring_enable && frame_live && bytes_due != '0) begin
          put_byte(op.data_byte);
          bytes_due = bytes_due - 1'b1;
          if (bytes_due == '0) begin
            frame_live = 1'b0;
            wr_pub     = wr_pend;
            rep.status = STS_PUBLISHED;
          end else begin
            rep.status = STS_ACCEPTED;
          end
        end
      end
      default: ;
    endcase
    rep.free_space = room_from(wr_pend);
    return rep;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("[cycle %0d] mismatch: %s", cycle_count, what);
    end
  endtask

  // Idle length after a handshake: mostly none or short, now and then long.
  function automatic int unsigned draw_gap(input bit enabled);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!enabled || roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  // Sender side: holds an item until it is taken, then idles for a random gap.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_replies.push_back(ring_predict(op_on_bus));
        src_gap = draw_gap(src_idle);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          op_on_bus = pending_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {op_on_bus.data_byte, op_on_bus.length, op_on_bus.command};
          s_axis_tuser  <= op_on_bus.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: checks every result item taken and stalls at random.
  always @(posedge clk_i) begin : reply_check
    ring_reply_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_replies.size() == 0) begin
          flag_mismatch($sformatf("result %h with nothing predicted", m_axis_tdata));
        end else begin
          want = predicted_replies.pop_front();
          if (m_axis_tdata[2:0] != want.status) begin
            flag_mismatch($sformatf("status %0d, predicted %0d",
                                    m_axis_tdata[2:0], want.status));
          end
          if (m_axis_tdata[10:3] != want.read_byte) begin
            flag_mismatch($sformatf("read_byte %h, predicted %h",
                                    m_axis_tdata[10:3], want.read_byte));
          end
          if (m_axis_tdata[24:11] != want.free_space) begin
            flag_mismatch($sformatf("free_space %0d, predicted %0d",
                                    m_axis_tdata[24:11], want.free_space));
          end
          if (m_axis_tdata[31:25] != '0) begin
            flag_mismatch($sformatf("padding bits %h not zero", m_axis_tdata[31:25]));
          end
        end
        sink_wait = draw_gap(sink_idle);
      end else if (m_axis_tready && sink_idle && $urandom_range(0, 15) == 0) begin
        // Stall now and then while the block is still busy, not only after a transfer.
        sink_wait = $urandom_range(1, 4);
      end
      if (sink_wait != 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Queues one item. Fields that the kind does not use carry random values.
  task automatic add_op(input logic [1:0] kind, input logic [23:0] field_val);
    ring_op_t op;
    op.mode      = kind;
    op.command   = 8'($urandom);
    op.length    = 16'($urandom);
    op.data_byte = 8'($urandom);
    if (kind == MODE_HDR) begin
      {op.length, op.command} = field_val;
    end else if (kind == MODE_PAY) begin
      op.data_byte = field_val[7:0];
    end
    pending_ops.push_back(op);
  endtask

  // Waits until the driver is empty and every predicted result has been taken.
  task automatic wait_idle();
    while (pending_ops.size() != 0 || s_axis_tvalid || predicted_replies.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_enable(input bit value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ring_enable = value;
    @(negedge clk_i);
  endtask

  // Mostly complete frames with random content and interleaved reads; the rest is
  // cut-short frames, oversized lengths, stray payload bytes and the unused kind.
  task automatic random_phase(input int unsigned n_ops);
    int unsigned made;
    int unsigned pick;
    int unsigned len;
    int unsigned sent;
    int unsigned k;
    made = 0;
    while (made < n_ops) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          len = $urandom_range(0, 16);
        end else if (pick < 95) begin
          len = $urandom_range(17, 120);
        end else begin
          len = $urandom_range(0, 65535);
        end
        add_op(MODE_HDR, {16'(len), 8'($urandom)});
        made++;
        // Huge frames only get a few bytes before the next header abandons them.
        sent = (len > 120) ? $urandom_range(0, 6) : len;
        if (sent != 0 && $urandom_range(0, 9) == 0) begin
          sent = $urandom_range(0, sent - 1);
        end
        for (k = 0; k < sent; k++) begin
          add_op(MODE_PAY, 24'($urandom));
          made++;
          if ($urandom_range(0, 1) == 0) begin
            add_op(MODE_READ, '0);
            made++;
          end
        end
      end else if (pick < 85) begin
        k = $urandom_range(1, 24);
        repeat (k) add_op(MODE_READ, '0);
        made += k;
      end else if (pick < 95) begin
        add_op(MODE_PAY, 24'($urandom));
        made++;
      end else begin
        add_op(MODE_SPARE, '0);
        made++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Disabled ring: headers and payload bytes are discarded, reads still answer.
    set_enable(1'b0);
    add_op(MODE_HDR, {16'hFFFF, 8'hFF});
    add_op(MODE_PAY, 24'h0000FF);
    add_op(MODE_READ, '0);
    wait_idle();

    // Directed cases, back to back with no idling on either side.
    set_enable(1'b1);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    add_op(MODE_READ, '0);                     // empty read
    add_op(MODE_HDR, {16'd0, 8'h00});          // empty payload publishes at once
    add_op(MODE_HDR, {16'd2, 8'hFF});
    add_op(MODE_PAY, 24'h0000FF);
    add_op(MODE_PAY, 24'h000000);              // last byte publishes the frame
    add_op(MODE_PAY, 24'h0000AA);              // stray byte, no frame open
    add_op(MODE_SPARE, '0);
    add_op(MODE_HDR, {16'd5, 8'h5A});
    add_op(MODE_PAY, 24'h000011);
    add_op(MODE_HDR, {16'hFFFF, 8'hA5});       // header while open, then no room
    add_op(MODE_PAY, 24'h000022);              // nothing open after the drop
    repeat (9) add_op(MODE_READ, '0);          // eight published bytes, then empty
    add_op(MODE_HDR, {16'hFFFF, 8'h3C});       // oversized but fits an empty ring
    add_op(MODE_HDR, {16'd16380, 8'h77});      // largest length that is kept as is
    add_op(MODE_HDR, {16'd16381, 8'h88});      // smallest length that gets cut
    add_op(MODE_HDR, {16'd1, 8'h01});
    add_op(MODE_PAY, 24'h000080);
    wait_idle();

    // Random phases, switching the ring on and off and varying the idling.
    for (int phase = 0; phase < 7; phase++) begin
      set_enable((phase == 1 || phase == 4) ? 1'b0 : 1'b1);
      src_idle  = (phase != 3);
      sink_idle = (phase != 2 && phase != 5);
      random_phase(ring_enable ? 210 : 40);
      wait_idle();
    end

    if (mismatch_count == 0 && predicted_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
